### sv/frac_pkg.sv
// Shared types, constants and command/status structs for the fraction unit.
`default_nettype none

package frac_pkg;

    // Operand width actually used from each fraction field (8 to 31).
    localparam int OPERAND_BITS = 31;

    // Fixed field widths of the transaction payloads.
    localparam int FIELD_W = 31;
    localparam int NUM_W   = 63;
    localparam int DEN_W   = 62;
    localparam int PROD_W  = 2 * OPERAND_BITS;
    localparam int K_W     = $clog2(NUM_W);
    localparam int CNT_W   = $clog2(NUM_W + 1);

    // Operation codes.
    localparam logic [1:0] OP_REDUCE = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_CMP    = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [FIELD_W-1:0] a_num;
        logic [FIELD_W-1:0] a_den;
        logic [FIELD_W-1:0] b_num;
        logic [FIELD_W-1:0] b_den;
    } t_in;

    typedef struct packed {
        logic [NUM_W-1:0] res_num;
        logic [DEN_W-1:0] res_den;
        logic             less;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_GCD,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SUM,
        ST_SUM_CHK,
        ST_MUL_CMP,
        ST_CMP
    } t_state;

    // Operand pair that the GCD loop and the divider work on.
    typedef enum logic [1:0] {
        SRC_A,
        SRC_DEN,
        SRC_SUM
    } t_src;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_L,
        MUL_T1,
        MUL_T2,
        MUL_X1,
        MUL_X2
    } t_mul_sel;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_PASS,
        RES_ZERO,
        RES_QUO,
        RES_SUMZ,
        RES_LESS
    } t_res_sel;

    typedef struct packed {
        logic     capture;
        logic     gcd_init;
        logic     gcd_step;
        t_src     src;
        logic     div_init;
        logic     div_step;
        t_mul_sel mul;
        logic     sum_en;
        t_res_sel res;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       a_num_zero;
        logic       a_den_zero;
        logic       b_den_zero;
        logic       gcd_done;
        logic       div_done;
        logic       sum_zero;
    } t_dp_stat;

endpackage

`default_nettype wire

### sv/frac_ctrl.sv
// Sequencing state machine of the fraction unit.
`default_nettype none

module frac_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  frac_pkg::t_dp_stat       i_stat,
    output frac_pkg::t_dp_cmd        o_cmd,
    output logic                     o_busy
);

    frac_pkg::t_state r_state;
    frac_pkg::t_state n_state;
    frac_pkg::t_src   r_src;
    frac_pkg::t_src   n_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frac_pkg::ST_IDLE;
            r_src   <= frac_pkg::SRC_A;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_src   = r_src;
        unique case (r_state)
            frac_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = frac_pkg::ST_DECODE;
                end
            end
            frac_pkg::ST_DECODE: begin
                unique case (i_stat.op)
                    frac_pkg::OP_REDUCE: begin
                        if (i_stat.a_num_zero || i_stat.a_den_zero) begin
                            n_state = frac_pkg::ST_IDLE;
                        end else begin
                            n_state = frac_pkg::ST_GCD;
                            n_src   = frac_pkg::SRC_A;
                        end
                    end
                    frac_pkg::OP_ADD: begin
                        if (i_stat.a_den_zero || i_stat.b_den_zero) begin
                            n_state = frac_pkg::ST_IDLE;
                        end else begin
                            n_state = frac_pkg::ST_GCD;
                            n_src   = frac_pkg::SRC_DEN;
                        end
                    end
                    frac_pkg::OP_CMP: begin
                        n_state = frac_pkg::ST_MUL_CMP;
                    end
                    default: begin
                        n_state = frac_pkg::ST_IDLE;
                    end
                endcase
            end
            frac_pkg::ST_GCD: begin
                if (i_stat.gcd_done) begin
                    n_state = frac_pkg::ST_DIV;
                end
            end
            frac_pkg::ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = (r_src == frac_pkg::SRC_DEN) ? frac_pkg::ST_MUL1
                                                           : frac_pkg::ST_IDLE;
                end
            end
            frac_pkg::ST_MUL1:    n_state = frac_pkg::ST_MUL2;
            frac_pkg::ST_MUL2:    n_state = frac_pkg::ST_MUL3;
            frac_pkg::ST_MUL3:    n_state = frac_pkg::ST_SUM;
            frac_pkg::ST_SUM:     n_state = frac_pkg::ST_SUM_CHK;
            frac_pkg::ST_SUM_CHK: begin
                if (i_stat.sum_zero) begin
                    n_state = frac_pkg::ST_IDLE;
                end else begin
                    n_state = frac_pkg::ST_GCD;
                    n_src   = frac_pkg::SRC_SUM;
                end
            end
            frac_pkg::ST_MUL_CMP: n_state = frac_pkg::ST_CMP;
            frac_pkg::ST_CMP:     n_state = frac_pkg::ST_IDLE;
            default:              n_state = frac_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd          = '0;
        o_cmd.src      = r_src;
        o_cmd.mul      = frac_pkg::MUL_NONE;
        o_cmd.res      = frac_pkg::RES_NONE;
        unique case (r_state)
            frac_pkg::ST_IDLE: begin
                o_cmd.capture = i_start;
            end
            frac_pkg::ST_DECODE: begin
                unique case (i_stat.op)
                    frac_pkg::OP_REDUCE: begin
                        if (i_stat.a_num_zero || i_stat.a_den_zero) begin
                            o_cmd.res = frac_pkg::RES_PASS;
                        end else begin
                            o_cmd.gcd_init = 1'b1;
                            o_cmd.src      = frac_pkg::SRC_A;
                        end
                    end
                    frac_pkg::OP_ADD: begin
                        if (i_stat.a_den_zero || i_stat.b_den_zero) begin
                            o_cmd.res = frac_pkg::RES_ZERO;
                        end else begin
                            o_cmd.gcd_init = 1'b1;
                            o_cmd.src      = frac_pkg::SRC_DEN;
                        end
                    end
                    frac_pkg::OP_CMP: begin
                        o_cmd.mul = frac_pkg::MUL_X1;
                    end
                    default: begin
                        o_cmd.res = frac_pkg::RES_ZERO;
                    end
                endcase
            end
            frac_pkg::ST_GCD: begin
                if (i_stat.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            frac_pkg::ST_DIV: begin
                if (!i_stat.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else if (r_src != frac_pkg::SRC_DEN) begin
                    o_cmd.res = frac_pkg::RES_QUO;
                end
            end
            frac_pkg::ST_MUL1:    o_cmd.mul = frac_pkg::MUL_L;
            frac_pkg::ST_MUL2:    o_cmd.mul = frac_pkg::MUL_T1;
            frac_pkg::ST_MUL3:    o_cmd.mul = frac_pkg::MUL_T2;
            frac_pkg::ST_SUM:     o_cmd.sum_en = 1'b1;
            frac_pkg::ST_SUM_CHK: begin
                if (i_stat.sum_zero) begin
                    o_cmd.res = frac_pkg::RES_SUMZ;
                end else begin
                    o_cmd.gcd_init = 1'b1;
                    o_cmd.src      = frac_pkg::SRC_SUM;
                end
            end
            frac_pkg::ST_MUL_CMP: o_cmd.mul = frac_pkg::MUL_X2;
            frac_pkg::ST_CMP:     o_cmd.res = frac_pkg::RES_LESS;
            default: begin
                o_cmd.res = frac_pkg::RES_NONE;
            end
        endcase
    end

    assign o_busy = (r_state != frac_pkg::ST_IDLE);

endmodule

`default_nettype wire

### sv/frac_dp.sv
// Datapath of the fraction unit: binary GCD, two-lane divider, multiplier, result register.
`default_nettype none

module frac_dp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  frac_pkg::t_in        i_in,
    input  frac_pkg::t_dp_cmd    i_cmd,
    output frac_pkg::t_dp_stat   o_stat,
    output frac_pkg::t_out       o_res,
    output logic                 o_done
);

    localparam int OB = frac_pkg::OPERAND_BITS;
    localparam int NW = frac_pkg::NUM_W;
    localparam int DW = frac_pkg::DEN_W;

    // Captured operands.
    logic [1:0]    r_op;
    logic [OB-1:0] r_an, r_ad, r_bn, r_bd;

    // GCD loop.
    logic [NW-1:0]             r_u, r_v;
    logic [frac_pkg::K_W-1:0]  r_k;

    // Divider: two lanes sharing one divisor.
    logic [NW-1:0]              r_dvs;
    logic [NW-1:0]              r_dq0, r_dq1;
    logic [NW-1:0]              r_rem0, r_rem1;
    logic [frac_pkg::CNT_W-1:0] r_dcnt;

    // Products and sum.
    logic [DW-1:0] r_m0, r_m1, r_m2;
    logic [NW-1:0] r_s;

    frac_pkg::t_out r_res;
    logic           r_done;

    logic [NW-1:0]     src_x, src_y;
    logic              src_short;
    logic [NW-1:0]     gcd_val;
    logic [NW:0]       rs0, rs1;
    logic              ge0, ge1;
    logic [NW:0]       rd0, rd1;
    logic [OB-1:0]     ma, mb;
    logic [frac_pkg::PROD_W-1:0] prod;

    // Operand pair selection for the GCD loop and the divider.
    always_comb begin
        case (i_cmd.src)
            frac_pkg::SRC_A: begin
                src_x = NW'(r_an);
                src_y = NW'(r_ad);
            end
            frac_pkg::SRC_DEN: begin
                src_x = NW'(r_ad);
                src_y = NW'(r_bd);
            end
            default: begin
                src_x = r_s;
                src_y = NW'(r_m0);
            end
        endcase
        src_short = (i_cmd.src != frac_pkg::SRC_SUM);
    end

    assign gcd_val = r_u << r_k;

    // One restoring step per lane.
    assign rs0 = {r_rem0, r_dq0[NW-1]};
    assign rs1 = {r_rem1, r_dq1[NW-1]};
    assign ge0 = (rs0 >= {1'b0, r_dvs});
    assign ge1 = (rs1 >= {1'b0, r_dvs});
    assign rd0 = rs0 - {1'b0, r_dvs};
    assign rd1 = rs1 - {1'b0, r_dvs};

    // Shared multiplier.
    always_comb begin
        case (i_cmd.mul)
            frac_pkg::MUL_L: begin
                ma = r_dq0[OB-1:0];
                mb = r_bd;
            end
            frac_pkg::MUL_T1: begin
                ma = r_an;
                mb = r_dq1[OB-1:0];
            end
            frac_pkg::MUL_T2: begin
                ma = r_bn;
                mb = r_dq0[OB-1:0];
            end
            frac_pkg::MUL_X1: begin
                ma = r_an;
                mb = r_bd;
            end
            frac_pkg::MUL_X2: begin
                ma = r_bn;
                mb = r_ad;
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod = ma * mb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_in.op;
            r_an <= i_in.a_num[OB-1:0];
            r_ad <= i_in.a_den[OB-1:0];
            r_bn <= i_in.b_num[OB-1:0];
            r_bd <= i_in.b_den[OB-1:0];
        end

        // Binary GCD: halve even values, subtract and halve when both are odd.
        if (i_cmd.gcd_init) begin
            r_u <= src_x;
            r_v <= src_y;
            r_k <= '0;
        end else if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u > r_v) begin
                r_u <= (r_u - r_v) >> 1;
            end else begin
                r_v <= (r_v - r_u) >> 1;
            end
        end

        // Short operands sit at the top of the dividend so fewer steps suffice.
        if (i_cmd.div_init) begin
            r_dvs  <= gcd_val;
            r_rem0 <= '0;
            r_rem1 <= '0;
            if (src_short) begin
                r_dq0 <= src_x << (NW - OB);
                r_dq1 <= src_y << (NW - OB);
            end else begin
                r_dq0 <= src_x;
                r_dq1 <= src_y;
            end
        end else if (i_cmd.div_step) begin
            r_rem0 <= ge0 ? rd0[NW-1:0] : rs0[NW-1:0];
            r_rem1 <= ge1 ? rd1[NW-1:0] : rs1[NW-1:0];
            r_dq0  <= {r_dq0[NW-2:0], ge0};
            r_dq1  <= {r_dq1[NW-2:0], ge1};
        end

        case (i_cmd.mul) inside
            frac_pkg::MUL_L:                    r_m0 <= DW'(prod);
            frac_pkg::MUL_T1, frac_pkg::MUL_X1: r_m1 <= DW'(prod);
            frac_pkg::MUL_T2, frac_pkg::MUL_X2: r_m2 <= DW'(prod);
            default: begin
            end
        endcase

        if (i_cmd.sum_en) begin
            r_s <= NW'(r_m1) + NW'(r_m2);
        end

        case (i_cmd.res)
            frac_pkg::RES_PASS: begin
                r_res.res_num <= NW'(r_an);
                r_res.res_den <= DW'(r_ad);
                r_res.less    <= 1'b0;
            end
            frac_pkg::RES_ZERO: begin
                r_res <= '0;
            end
            frac_pkg::RES_QUO: begin
                r_res.res_num <= r_dq0;
                r_res.res_den <= r_dq1[DW-1:0];
                r_res.less    <= 1'b0;
            end
            frac_pkg::RES_SUMZ: begin
                r_res.res_num <= '0;
                r_res.res_den <= r_m0;
                r_res.less    <= 1'b0;
            end
            frac_pkg::RES_LESS: begin
                r_res.res_num <= '0;
                r_res.res_den <= '0;
                r_res.less    <= (r_m1 < r_m2);
            end
            default: begin
            end
        endcase

        if (!i_rst_n) begin
            r_dcnt <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (i_cmd.res != frac_pkg::RES_NONE);
            if (i_cmd.div_init) begin
                r_dcnt <= src_short ? frac_pkg::CNT_W'(OB) : frac_pkg::CNT_W'(NW);
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt - 1'b1;
            end
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.a_num_zero = (r_an == '0);
    assign o_stat.a_den_zero = (r_ad == '0);
    assign o_stat.b_den_zero = (r_bd == '0);
    assign o_stat.gcd_done   = (r_u == r_v);
    assign o_stat.div_done   = (r_dcnt == '0);
    assign o_stat.sum_zero   = (r_s == '0);

    assign o_res  = r_res;
    assign o_done = r_done;

endmodule

`default_nettype wire

### sv/fraction_add_reduce_compare.sv
// Top level of the fraction reduce, add and compare unit.
`default_nettype none

// Exact arithmetic on two non-negative fractions A and B, one transaction at a
// time. A transaction is taken at a rising edge where start is high and busy is
// low; its single result appears on o_res for exactly one cycle with o_done high,
// and the receiver has no way to hold it off, so it must take every strobe.
// Reduce (op 0) divides A by the GCD of its parts; add (op 1) forms the sum over
// the least common multiple of the denominators and reduces it; compare (op 2)
// sets less from exact cross products. A zero numerator is not reduced, a zero
// denominator in reduce passes A through, a zero denominator in add gives 0/0,
// and the unused op code gives all zeros.
// The pass-through and zero cases end at decode. Compare forms its two cross
// products and compares them. Reduce runs the binary GCD loop and then the
// divider; add runs the GCD loop and the divider on the denominators, three
// multiplies and the sum, then the GCD loop and the divider again on a nonzero
// sum and the least common multiple. The divider yields one quotient bit per
// cycle, and its two lanes divide numerator and denominator by the GCD at the
// same time. busy stays high while a transaction runs and falls in the cycle
// that o_done is high, so the next transaction can be taken while a result is
// being presented.

module fraction_add_reduce_compare (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    input  frac_pkg::t_in    i_in,
    output logic             busy,
    output frac_pkg::t_out   o_res,
    output logic             o_done
);

    frac_pkg::t_dp_cmd  cmd;
    frac_pkg::t_dp_stat stat;

    // Sequencer: decides what the datapath does each cycle.
    frac_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Datapath: operand capture, GCD, divider, multiplier and result register.
    frac_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_res),
        .o_done  (o_done)
    );

`ifndef NO_ASSERTIONS
    logic accept;
    assign accept = start && !busy;

    // An accepted transaction always makes the unit busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("unit not busy after an accepted transaction");

    // Result strobes never come back to back.
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back result strobes");

    // An accepted compare always delivers its result on time.
    a_cmp_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in.op == frac_pkg::OP_CMP) |-> ##4 o_done)
        else $error("compare result not delivered on time");

    // A result with less set carries no fraction.
    a_less_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.less |-> (o_res.res_num == '0) && (o_res.res_den == '0))
        else $error("compare result carries a fraction");
`endif

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the fraction reduce, add and compare unit.
`default_nettype none

module tb;

    // Op code 3 has no operation behind it. The block must answer it with all zeros.
    localparam logic [1:0]                  OP_UNUSED  = 2'd3;
    localparam logic [frac_pkg::FIELD_W-1:0] MAX_OPND  = {frac_pkg::FIELD_W{1'b1}};
    localparam int                          RAND_ITEMS = 1500;
    localparam int                          MAX_PRINTS = 40;

    typedef struct {
        frac_pkg::t_in  stim;
        bit             typed;
        frac_pkg::t_out want;
    } t_stim_row;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    frac_pkg::t_in  i_in    = '0;
    logic           busy;
    frac_pkg::t_out o_res;
    logic           o_done;

    frac_pkg::t_out pending_results[$];
    t_stim_row      stim_table[$];
    int             mismatch_count = 0;
    bit             no_idle        = 1'b0;

    fraction_add_reduce_compare u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_in    (i_in),
        .busy    (busy),
        .o_res   (o_res),
        .o_done  (o_done)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // This timeout leaves a wide margin over the slowest add for every item plus
    // the largest gaps.
    initial begin
        #(12 * 3_000_000);
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Exact result of one transaction at the block's widths.
    function automatic frac_pkg::t_out fraction_result(input frac_pkg::t_in item);
        logic [63:0]    opnd_mask;
        logic [63:0]    an, ad, bn, bd, g, lcm, rn, rd;
        frac_pkg::t_out r;
        opnd_mask = (64'd1 << frac_pkg::OPERAND_BITS) - 64'd1;
        an = 64'(item.a_num) & opnd_mask;
        ad = 64'(item.a_den) & opnd_mask;
        bn = 64'(item.b_num) & opnd_mask;
        bd = 64'(item.b_den) & opnd_mask;
        rn = '0;
        rd = '0;
        r  = '0;
        case (item.op)
            frac_pkg::OP_REDUCE: begin
                rn = an;
                rd = ad;
            end
            frac_pkg::OP_ADD: begin
                if (ad != 0 && bd != 0) begin
                    g   = gcd64(ad, bd);
                    lcm = (ad / g) * bd;
                    rn  = an * (lcm / ad) + bn * (lcm / bd);
                    rd  = lcm;
                end
            end
            frac_pkg::OP_CMP: begin
                r.less = (an * bd < bn * ad);
            end
            default: ;
        endcase
        // A zero numerator or denominator is never reduced.
        if (rn != 0 && rd != 0) begin
            g  = gcd64(rn, rd);
            rn = rn / g;
            rd = rd / g;
        end
        r.res_num = rn[frac_pkg::NUM_W-1:0];
        r.res_den = rd[frac_pkg::DEN_W-1:0];
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] op,
                                    input logic [frac_pkg::FIELD_W-1:0] an,
                                    input logic [frac_pkg::FIELD_W-1:0] ad,
                                    input logic [frac_pkg::FIELD_W-1:0] bn,
                                    input logic [frac_pkg::FIELD_W-1:0] bd, input bit typed,
                                    input logic [63:0] rn, input logic [63:0] rd,
                                    input logic lt);
        t_stim_row row;
        row.stim  = '{op: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
        row.typed = typed;
        row.want  = '{res_num: rn[frac_pkg::NUM_W-1:0], res_den: rd[frac_pkg::DEN_W-1:0],
                      less: lt};
        stim_table.push_back(row);
    endfunction

    function automatic logic [frac_pkg::FIELD_W-1:0] rand_field();
        case ($urandom_range(0, 7))
            0, 1, 2: return frac_pkg::FIELD_W'($urandom());
            3, 4:    return frac_pkg::FIELD_W'($urandom_range(1, 1000));
            5:       return $urandom_range(0, 1) ? MAX_OPND : frac_pkg::FIELD_W'(1);
            default: return frac_pkg::FIELD_W'($urandom_range(1, 1 << 20));
        endcase
    endfunction

    // Offers one transaction after a random gap and waits until the block takes it.
    // When no gap is drawn, start simply stays high from the previous transaction.
    task automatic send_item(input frac_pkg::t_in item, input bit typed,
                             input frac_pkg::t_out want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= item;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(typed ? want : fraction_result(item));
    endtask

    // A result is strobed for one cycle only, so every strobe is checked.
    always @(posedge i_clk) begin
        frac_pkg::t_out want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, res_num", 64'(o_res.res_num), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_res.res_num !== want.res_num)
                    report_mismatch("res_num", 64'(o_res.res_num), 64'(want.res_num));
                if (o_res.res_den !== want.res_den)
                    report_mismatch("res_den", 64'(o_res.res_den), 64'(want.res_den));
                if (o_res.less !== want.less)
                    report_mismatch("less", 64'(o_res.less), 64'(want.less));
            end
        end
    end

    initial begin
        frac_pkg::t_in item;
        int unsigned   factor;
        int            op_pick;

        // Directed rows: zero numerators and denominators, the largest operands,
        // sums whose common denominator nears 62 bits, ties in compare and op 3.
        add_row(frac_pkg::OP_REDUCE, 0, 5, 0, 1, 1, 0, 5, 0);
        add_row(frac_pkg::OP_REDUCE, 7, 0, 3, 3, 1, 7, 0, 0);
        add_row(frac_pkg::OP_REDUCE, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(frac_pkg::OP_REDUCE, 6, 4, 1, 1, 1, 3, 2, 0);
        add_row(frac_pkg::OP_REDUCE, MAX_OPND, MAX_OPND, 0, 1, 1, 1, 1, 0);
        add_row(frac_pkg::OP_REDUCE, MAX_OPND, MAX_OPND - 1, MAX_OPND, MAX_OPND, 1,
                64'(MAX_OPND), 64'(MAX_OPND - 1), 0);
        add_row(frac_pkg::OP_REDUCE, 31'h4000_0000, 31'h0000_3000, 0, 1, 0, 0, 0, 0);
        add_row(frac_pkg::OP_ADD, 1, 2, 1, 3, 1, 5, 6, 0);
        add_row(frac_pkg::OP_ADD, 0, 3, 0, 5, 1, 0, 15, 0);
        add_row(frac_pkg::OP_ADD, 1, 0, 1, 3, 1, 0, 0, 0);
        add_row(frac_pkg::OP_ADD, 1, 3, 1, 0, 1, 0, 0, 0);
        add_row(frac_pkg::OP_ADD, MAX_OPND, MAX_OPND, MAX_OPND, MAX_OPND, 1, 2, 1, 0);
        add_row(frac_pkg::OP_ADD, MAX_OPND, 1, MAX_OPND, 1, 1, 64'd4294967294, 1, 0);
        add_row(frac_pkg::OP_ADD, 1, MAX_OPND, 1, MAX_OPND - 1, 0, 0, 0, 0);
        add_row(frac_pkg::OP_ADD, MAX_OPND, MAX_OPND - 1, MAX_OPND - 1, MAX_OPND, 0,
                0, 0, 0);
        add_row(frac_pkg::OP_ADD, 1, 6, 1, 10, 0, 0, 0, 0);
        add_row(frac_pkg::OP_CMP, 1, 2, 2, 3, 1, 0, 0, 1);
        add_row(frac_pkg::OP_CMP, 2, 3, 1, 2, 1, 0, 0, 0);
        add_row(frac_pkg::OP_CMP, 2, 4, 1, 2, 1, 0, 0, 0);
        add_row(frac_pkg::OP_CMP, 1, 0, 1, 1, 1, 0, 0, 0);
        add_row(frac_pkg::OP_CMP, 1, 1, 1, 0, 1, 0, 0, 1);
        add_row(frac_pkg::OP_CMP, 0, 1, 1, MAX_OPND, 1, 0, 0, 1);
        add_row(frac_pkg::OP_CMP, MAX_OPND, 1, MAX_OPND, 1, 1, 0, 0, 0);
        add_row(frac_pkg::OP_CMP, MAX_OPND - 1, MAX_OPND, MAX_OPND, MAX_OPND - 1, 0,
                0, 0, 0);
        add_row(OP_UNUSED, MAX_OPND, MAX_OPND, MAX_OPND, MAX_OPND, 1, 0, 0, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[i])
            send_item(stim_table[i].stim, stim_table[i].typed, stim_table[i].want);

        // Mostly well-formed fractions, half of them sharing a factor so that
        // reduction has work to do, with zero fields and op 3 as noise.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 50 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            op_pick = $urandom_range(0, 99);
            item.op = (op_pick < 30) ? frac_pkg::OP_REDUCE :
                      (op_pick < 70) ? frac_pkg::OP_ADD :
                      (op_pick < 95) ? frac_pkg::OP_CMP : OP_UNUSED;
            item.a_num = rand_field();
            item.a_den = rand_field();
            item.b_num = rand_field();
            item.b_den = rand_field();
            if ($urandom_range(0, 1) == 1) begin
                factor     = $urandom_range(2, 5000);
                item.a_num = frac_pkg::FIELD_W'($urandom_range(0, 400000) * factor);
                item.a_den = frac_pkg::FIELD_W'($urandom_range(1, 400000) * factor);
                item.b_den = frac_pkg::FIELD_W'($urandom_range(1, 400000) * factor);
            end
            if ($urandom_range(0, 29) == 0) item.a_num = '0;
            if ($urandom_range(0, 29) == 0) item.b_num = '0;
            if ($urandom_range(0, 39) == 0) item.a_den = '0;
            if ($urandom_range(0, 39) == 0) item.b_den = '0;
            send_item(item, 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        // Keep the clock running to catch any stray strobe after the last result.
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
